[design/rgbg_pkg.sv]
// ----------------------------------------------------------------------------
// rgbg_pkg
// Shared types and constants for the RGB piecewise-linear gamma block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbg_pkg;

    localparam int KNOT_COUNT = 257;
    localparam int KNOT_IDX_W = $clog2(KNOT_COUNT);
    localparam int KNOT_W     = 14;
    localparam int SAMPLE_W   = 16;
    localparam int SEG_W      = 8;
    localparam int FRAC_W     = 6;
    localparam int OUT_SIG_W  = 10;
    localparam int PIPE_DEPTH = 4;

    localparam logic [KNOT_W-1:0] KNOT_MAX = 14'h3FFF;
    localparam logic [SEG_W-1:0]  LAST_SEG = 8'd255;

    // floor(x/63) = (x * RECIP_63) >> RECIP_SHIFT for x < 2^21
    localparam logic [21:0] RECIP_63    = 22'd2130441;
    localparam int          RECIP_SHIFT = 27;

    // falling segment: prod = 2^32 - m, quotient = base - floor((m + bias) / D)
    localparam logic [20:0]       NEG_BIAS_63 = 21'd58;
    localparam logic [20:0]       NEG_BIAS_64 = 21'd63;
    localparam logic [KNOT_W-1:0] NEG_BASE_63 = 14'd260;   // (2^32 / 63) mod 2^14
    localparam logic [KNOT_W-1:0] NEG_BASE_64 = 14'd0;     // (2^26) mod 2^14

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_KNOT  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic                  adv;
        logic                  wr_en;
        logic [KNOT_IDX_W-1:0] wr_idx;
        logic [KNOT_W-1:0]     wr_val;
    } t_pipe_ctrl;

endpackage

`default_nettype wire

[design/rgbg_chan.sv]
// ----------------------------------------------------------------------------
// rgbg_chan
// One color channel: knot table copy, interpolation pipeline, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbg_chan (
    input  wire logic                            i_clk,
    input  wire rgbg_pkg::t_pipe_ctrl            i_ctrl,
    input  wire logic [rgbg_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire logic                            i_bypass,
    output logic      [rgbg_pkg::SAMPLE_W-1:0]   o_result
);

    localparam int KW = rgbg_pkg::KNOT_W;
    localparam int IW = rgbg_pkg::KNOT_IDX_W;
    localparam int FW = rgbg_pkg::FRAC_W;
    localparam int BW = rgbg_pkg::OUT_SIG_W;
    localparam int MW = KW + FW;

    logic [KW-1:0] r_mem [rgbg_pkg::KNOT_COUNT];

    logic [IW-1:0] w_rd0;
    logic [IW-1:0] w_rd1;

    // stage 1: knot read
    logic [KW-1:0] r_k0_1;
    logic [KW-1:0] r_k1_1;
    logic [FW-1:0] r_f_1;
    logic          r_last_1;
    logic [BW-1:0] r_byp_1;

    // stage 2: |k1 - k0| * f
    logic          n_neg_2;
    logic [KW-1:0] n_diff_2;
    logic [MW-1:0] r_m_2;
    logic          r_neg_2;
    logic          r_last_2;
    logic [KW-1:0] r_k0_2;
    logic [BW-1:0] r_byp_2;

    // stage 3: divide by 63 or 64
    logic [MW:0]   n_x_3;
    logic [42:0]   n_prod_3;
    logic [KW-1:0] r_q_3;
    logic          r_neg_3;
    logic          r_last_3;
    logic [KW-1:0] r_k0_3;
    logic [BW-1:0] r_byp_3;

    // stage 4: result
    logic [KW-1:0] n_q_4;
    logic [KW-1:0] n_lut_4;
    logic [rgbg_pkg::SAMPLE_W-1:0] r_out;

    assign w_rd0 = {1'b0, i_sample[15:8]};
    assign w_rd1 = w_rd0 + IW'(1);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_idx] <= i_ctrl.wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_k0_1   <= r_mem[w_rd0];
            r_k1_1   <= r_mem[w_rd1];
            r_f_1    <= i_sample[7:2];
            r_last_1 <= (i_sample[15:8] == rgbg_pkg::LAST_SEG);
            r_byp_1  <= i_sample[15:6];
        end
    end

    always_comb begin
        n_neg_2  = (r_k1_1 < r_k0_1);
        n_diff_2 = n_neg_2 ? (r_k0_1 - r_k1_1) : (r_k1_1 - r_k0_1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_m_2    <= MW'(n_diff_2) * MW'(r_f_1);
            r_neg_2  <= n_neg_2 && (r_f_1 != '0);
            r_last_2 <= r_last_1;
            r_k0_2   <= r_k0_1;
            r_byp_2  <= r_byp_1;
        end
    end

    always_comb begin
        priority if (!r_neg_2) begin
            n_x_3 = {1'b0, r_m_2};
        end else if (r_last_2) begin
            n_x_3 = {1'b0, r_m_2} + rgbg_pkg::NEG_BIAS_63;
        end else begin
            n_x_3 = {1'b0, r_m_2} + rgbg_pkg::NEG_BIAS_64;
        end
        n_prod_3 = 43'(n_x_3) * 43'(rgbg_pkg::RECIP_63);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            if (r_last_2) begin
                r_q_3 <= n_prod_3[rgbg_pkg::RECIP_SHIFT +: KW];
            end else begin
                r_q_3 <= n_x_3[FW +: KW];
            end
            r_neg_3  <= r_neg_2;
            r_last_3 <= r_last_2;
            r_k0_3   <= r_k0_2;
            r_byp_3  <= r_byp_2;
        end
    end

    // only bits 13:4 of the 32-bit sum reach the output
    always_comb begin
        priority if (!r_neg_3) begin
            n_q_4 = r_q_3;
        end else if (r_last_3) begin
            n_q_4 = rgbg_pkg::NEG_BASE_63 - r_q_3;
        end else begin
            n_q_4 = rgbg_pkg::NEG_BASE_64 - r_q_3;
        end
        n_lut_4 = r_k0_3 + n_q_4;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            if (i_bypass) begin
                r_out <= {r_byp_3, 6'b0};
            end else begin
                r_out <= {n_lut_4[KW-1:4], 6'b0};
            end
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

[design/rgb_gamma_piecewise_linear.sv]
// ----------------------------------------------------------------------------
// rgb_gamma_piecewise_linear
// 257-knot piecewise-linear gamma curve on 16-bit RGB pixels.
// ----------------------------------------------------------------------------
// Takes one request per clock, pixel or knot write, unless the output stalls,
// and returns each pixel through its stages in order: knot read, difference
// times fraction, divide by 64 (or 63 in the last segment), final add into the
// result register. The rate is set by the knot table, held as one copy per
// channel with two read ports each, so both neighbor knots of all three
// channels are read in the same cycle. Knot writes go to all copies and give
// no result. A stall on the output holds the whole pipeline. Knots must be
// written before any pixel reads them.
`default_nettype none

module rgb_gamma_piecewise_linear (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_bypass,

    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_red_in,
    input  wire logic [15:0] i_green_in,
    input  wire logic [15:0] i_blue_in,
    input  wire logic [8:0]  i_knot_index,
    input  wire logic [15:0] i_knot_value,

    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_red_out,
    output logic [15:0]      o_green_out,
    output logic [15:0]      o_blue_out
);

    localparam int PD = rgbg_pkg::PIPE_DEPTH;

    logic                 r_bypass;
    logic [PD-1:0]        r_vld;
    logic                 w_adv;
    logic                 w_accept;
    rgbg_pkg::t_pipe_ctrl w_ctrl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b0;
        end else if (i_cfg_valid) begin
            r_bypass <= i_cfg_bypass;
        end
    end

    assign w_adv    = !r_vld[PD-1] || i_ready;
    assign o_ready  = w_adv;
    assign w_accept = i_valid && w_adv;

    always_comb begin
        w_ctrl.adv    = w_adv;
        w_ctrl.wr_en  = w_accept && (i_opcode == rgbg_pkg::OP_KNOT)
                        && (i_knot_index < rgbg_pkg::KNOT_IDX_W'(rgbg_pkg::KNOT_COUNT));
        w_ctrl.wr_idx = i_knot_index;
        w_ctrl.wr_val = (i_knot_value[15:14] != 2'b00) ? rgbg_pkg::KNOT_MAX
                                                      : i_knot_value[13:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PD-2:0], w_accept && (i_opcode == rgbg_pkg::OP_PIXEL)};
        end
    end

    assign o_valid = r_vld[PD-1];

    rgbg_chan u_red (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_sample (i_red_in),
        .i_bypass (r_bypass),
        .o_result (o_red_out)
    );

    rgbg_chan u_green (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_sample (i_green_in),
        .i_bypass (r_bypass),
        .o_result (o_green_out)
    );

    rgbg_chan u_blue (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_sample (i_blue_in),
        .i_bypass (r_bypass),
        .o_result (o_blue_out)
    );

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline valids moved during a stall");

    a_ready_only_blocked_by_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result waiting");

    a_knot_gives_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_opcode == rgbg_pkg::OP_KNOT)) |=> !r_vld[0])
        else $error("knot write entered the pipeline as a pixel");

    a_low_bits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red_out[5:0] == 6'd0) && (o_green_out[5:0] == 6'd0)
                    && (o_blue_out[5:0] == 6'd0))
        else $error("result not left-aligned to 10 bits");

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for rgb_gamma_piecewise_linear.
// ----------------------------------------------------------------------------
// Sends three bypass pixels, fills the knot table, then sends directed and
// random pixel and knot-write requests with random gaps on both handshakes.
// The bypass register is switched between phases. A scoreboard predicts each
// pixel from its own copy of the curve and checks the outputs in order.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_rgb_px;

    class t_gamma_scoreboard;
        logic [rgbg_pkg::KNOT_W-1:0] knots [rgbg_pkg::KNOT_COUNT];
        logic                        bypass = 1'b0;
        t_rgb_px                     expected_px [$];
        int unsigned                 mismatches = 0;

        function void set_bypass(logic b);
            bypass = b;
        endfunction

        function int unsigned pending();
            return expected_px.size();
        endfunction

        function logic [15:0] curve(logic [15:0] sample);
            logic [13:0] v;
            logic [7:0]  seg;
            logic [31:0] frac;
            logic [31:0] k0;
            logic [31:0] k1;
            logic [31:0] prod;
            logic [31:0] lut;
            v = sample[15:2];
            if (bypass) begin
                return {sample[15:6], 6'b0};
            end
            seg  = v[13:6];
            frac = {26'b0, v[5:0]};
            k0   = {18'b0, knots[int'(seg)]};
            k1   = {18'b0, knots[int'(seg) + 1]};
            prod = (k1 - k0) * frac;
            lut  = k0 + prod / ((seg == rgbg_pkg::LAST_SEG) ? 32'd63 : 32'd64);
            return {lut[13:4], 6'b0};
        endfunction

        function void note_request(rgbg_pkg::t_opcode op, logic [15:0] r,
                                   logic [15:0] g, logic [15:0] b,
                                   logic [8:0] idx, logic [15:0] val);
            t_rgb_px px;
            if (op == rgbg_pkg::OP_KNOT) begin
                if (idx < rgbg_pkg::KNOT_COUNT) begin
                    knots[idx] = (val > rgbg_pkg::KNOT_MAX) ? rgbg_pkg::KNOT_MAX
                                                            : val[rgbg_pkg::KNOT_W-1:0];
                end
            end else begin
                px.red   = curve(r);
                px.green = curve(g);
                px.blue  = curve(b);
                expected_px = {expected_px, px};
            end
        endfunction

        function void flag(string field, logic [15:0] want, logic [15:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s: expected %h, got %h", field, want, got);
            end
        endfunction

        function void check_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
            t_rgb_px want;
            if (expected_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: %h %h %h", r, g, b);
                end
                return;
            end
            want = expected_px.pop_front();
            if (r !== want.red)   flag("red", want.red, r);
            if (g !== want.green) flag("green", want.green, g);
            if (b !== want.blue)  flag("blue", want.blue, b);
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_bypass = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic        i_opcode     = 1'b0;
    logic [15:0] i_red_in     = '0;
    logic [15:0] i_green_in   = '0;
    logic [15:0] i_blue_in    = '0;
    logic [8:0]  i_knot_index = '0;
    logic [15:0] i_knot_value = '0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [15:0] o_red_out;
    logic [15:0] o_green_out;
    logic [15:0] o_blue_out;

    t_gamma_scoreboard sb;
    bit                quiet        = 1'b0;
    bit                hold_off_req = 1'b0;
    int unsigned       idle_cycles  = 0;

    rgb_gamma_piecewise_linear dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_bypass (i_cfg_bypass),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_knot_index (i_knot_index),
        .i_knot_value (i_knot_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return 16'($urandom_range(0, 65535));
        if (r < 85) return 16'h0000;
        if (r < 90) return 16'hFFFF;
        if (r < 95) return {8'hFF, 8'($urandom)};
        return {8'($urandom), 6'h3F, 2'($urandom)};
    endfunction

    function automatic logic [15:0] rand_knot_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, 16383));
        if (r < 80) return 16'd16383;
        if (r < 85) return 16'd0;
        return 16'($urandom_range(16384, 65535));
    endfunction

    // posedge sampling: all values seen here are the ones held before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_request(rgbg_pkg::t_opcode'(i_opcode), i_red_in, i_green_in,
                                i_blue_in, i_knot_index, i_knot_value);
            end
            if (o_valid && i_ready) begin
                sb.check_pixel(o_red_out, o_green_out, o_blue_out);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_bypass(i_cfg_bypass);
            end
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // output side: random back-pressure, one long hold-off on request
    initial begin
        int unsigned gap;
        forever begin
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            i_ready <= 1'b1;
            repeat (1 + $urandom_range(0, 20)) @(posedge i_clk);
            gap = pick_gap();
            if (gap != 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    task automatic send_request(rgbg_pkg::t_opcode op, logic [15:0] r, logic [15:0] g,
                                logic [15:0] b, logic [8:0] idx, logic [15:0] val);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_opcode     <= op;
        i_red_in     <= r;
        i_green_in   <= g;
        i_blue_in    <= b;
        i_knot_index <= idx;
        i_knot_value <= val;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        send_request(rgbg_pkg::OP_PIXEL, r, g, b, 9'($urandom), 16'($urandom));
    endtask

    task automatic send_knot(logic [8:0] idx, logic [15:0] val);
        send_request(rgbg_pkg::OP_KNOT, 16'($urandom), 16'($urandom), 16'($urandom),
                     idx, val);
    endtask

    task automatic write_bypass(logic b);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_bypass <= b;
        i_cfg_valid  <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(int unsigned n);
        int unsigned r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                send_pixel(rand_sample(), rand_sample(), rand_sample());
            end else if (r < 95) begin
                send_knot(9'($urandom_range(0, rgbg_pkg::KNOT_COUNT - 1)), rand_knot_value());
            end else begin
                send_knot(9'($urandom_range(rgbg_pkg::KNOT_COUNT, 511)), rand_knot_value());
            end
        end
    endtask

    initial begin
        logic [15:0] kv;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bypass pixels need no knots
        write_bypass(1'b1);
        send_pixel(16'h0000, 16'hFFFF, 16'h003F);
        send_pixel(16'h0040, 16'hFFC0, 16'h8000);
        send_pixel(16'hAAAA, 16'h5555, 16'h7FFF);

        // fill the whole curve before any curve lookup
        for (int k = 0; k < rgbg_pkg::KNOT_COUNT; k++) begin
            kv = 16'(k * 63 + $urandom_range(0, 40));
            if (k == 0) kv = 16'd0;
            if (k == 128) kv = 16'd20000;
            if (k == rgbg_pkg::KNOT_COUNT - 1) kv = 16'hFFFF;
            send_knot(9'(k), kv);
            if (k == 100) send_knot(9'd257, 16'd777);
            if (k == 200) send_knot(9'd511, 16'hFFFF);
        end

        write_bypass(1'b0);
        send_pixel(16'h0000, 16'hFFFF, 16'hFF00);
        send_pixel(16'hFEFF, 16'h0100, 16'h00FF);
        send_pixel(16'hFFFC, 16'h0003, 16'h8040);
        // falling segments, first and last
        send_knot(9'd255, 16'd16383);
        send_knot(9'd256, 16'd0);
        send_knot(9'd0, 16'd16383);
        send_knot(9'd1, 16'd0);
        send_pixel(16'hFFFF, 16'h00FC, 16'hFF80);
        // steepest rise in the last segment, saturated top knot
        send_knot(9'd255, 16'd0);
        send_knot(9'd256, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFE, 16'hFF04);
        // ignored writes must leave the table alone
        send_knot(9'd300, 16'd1234);
        send_knot(9'h1FF, 16'd0);
        send_pixel(16'hFFFF, 16'h0040, 16'h7FC0);

        random_requests(100);
        write_bypass(1'b1);
        random_requests(70);
        write_bypass(1'b0);
        quiet = 1'b1;
        hold_off_req = 1'b1;
        random_requests(140);
        quiet = 1'b0;
        write_bypass(1'b1);
        quiet = 1'b1;
        random_requests(90);
        quiet = 1'b0;
        write_bypass(1'b0);
        random_requests(170);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[rgb_gamma_piecewise_linear.f]
design/rgbg_pkg.sv
design/rgbg_chan.sv
design/rgb_gamma_piecewise_linear.sv
sim/tb.sv
